// ===== src/mlpq_pkg.sv =====
`default_nettype none
package mlpq_pkg;

	localparam int MAX_LEVELS  = 8;
	localparam int LEVEL_DEPTH = 16;

	localparam int KIND_W   = 2;
	localparam int PRIO_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int TOTAL_W  = 8;
	localparam int LCOUNT_W = 5;
	localparam int ERR_W    = 2;

	localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PTR_W  = $clog2(LEVEL_DEPTH);
	localparam int OCC_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int MEM_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
	localparam int ADDR_W = $clog2(MEM_DEPTH);

	localparam logic [PRIO_W-1:0] NUM_LEVELS_RESET = PRIO_W'(MAX_LEVELS);

	localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEQ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_PRIO  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [PRIO_W-1:0]         element_priority;
		logic signed [VALUE_W-1:0] element_value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] head_value;
		logic [PRIO_W-1:0]         head_priority;
		logic                      queue_empty;
		logic [TOTAL_W-1:0]        total_count;
		logic [LCOUNT_W-1:0]       level_count;
		logic [ERR_W-1:0]          error_code;
	} rsp_t;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic find_top;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/mlpq_ifs.sv =====
`default_nettype none
interface mlpq_req_if;
	import mlpq_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlpq_rsp_if;
	import mlpq_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mlpq_cfg_if;
	import mlpq_pkg::*;
	logic              valid;
	logic              ready;
	logic [PRIO_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/mlpq_ctrl.sv =====
`default_nettype none
module mlpq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  mlpq_pkg::stat_t     stat,
	output mlpq_pkg::cmd_t      cmd
);
	import mlpq_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_TOP  = 4'b0100,
		S_LOAD = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_TOP;
			end
			S_TOP: begin
				cmd.find_top = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted transaction did not start execution");
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded while output register busy");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_item, cmd.exec, cmd.find_top, cmd.load_out}))
		else $error("more than one datapath command");

endmodule
`default_nettype wire

// ===== src/mlpq_datapath.sv =====
`default_nettype none
module mlpq_datapath (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  mlpq_pkg::req_t req_data,
	input  mlpq_pkg::cmd_t cmd,
	output mlpq_pkg::stat_t stat,
	mlpq_cfg_if.sink       cfg,
	mlpq_rsp_if.source     rsp
);
	import mlpq_pkg::*;

	logic [PRIO_W-1:0]  num_levels_q;
	logic [KIND_W-1:0]  kind_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [VALUE_W-1:0] val_q;
	logic [ERR_W-1:0]   err_q;

	logic [PTR_W-1:0] head_q [MAX_LEVELS];
	logic [PTR_W-1:0] tail_q [MAX_LEVELS];
	logic [OCC_W-1:0] occ_q  [MAX_LEVELS];

	logic [VALUE_W-1:0] mem [MEM_DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	logic               top_valid_q;
	logic [LVL_W-1:0]   top_lvl_q;
	logic [TOTAL_W-1:0] total_q;
	logic [OCC_W-1:0]   lvl_cnt_q;
	logic               out_valid_q;
	rsp_t               out_q;

	logic [PRIO_W-1:0]  lvl_use;
	logic               prio_ok;
	logic [LVL_W-1:0]   req_lvl;
	logic               top_found;
	logic [LVL_W-1:0]   top_idx;
	logic [TOTAL_W-1:0] total_sum;
	logic               enq_ok;
	logic               is_enq;
	logic               is_deq;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] mem_addr(input logic [LVL_W-1:0] l,
		input logic [PTR_W-1:0] p);
		return ADDR_W'(l) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(p);
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_levels_q <= NUM_LEVELS_RESET;
		end else if (cfg.valid) begin
			num_levels_q <= cfg.data;
		end
	end

	// clamp the programmed level count into 1..MAX_LEVELS
	always_comb begin
		if (num_levels_q == '0) begin
			lvl_use = PRIO_W'(1);
		end else if (num_levels_q > PRIO_W'(MAX_LEVELS)) begin
			lvl_use = PRIO_W'(MAX_LEVELS);
		end else begin
			lvl_use = num_levels_q;
		end
	end

	assign prio_ok = (prio_q != '0) && (prio_q <= lvl_use);
	assign req_lvl = LVL_W'(prio_q - 1'b1);
	assign is_enq  = (kind_q == KIND_ENQ);
	assign is_deq  = (kind_q == KIND_DEQ);
	assign enq_ok  = is_enq && prio_ok && (occ_q[req_lvl] != OCC_W'(LEVEL_DEPTH));

	// highest non-empty level in use wins
	always_comb begin
		top_found = 1'b0;
		top_idx = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if ((i < int'(lvl_use)) && (occ_q[i] != '0)) begin
				top_found = 1'b1;
				top_idx = LVL_W'(i);
			end
		end
	end

	always_comb begin
		total_sum = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			if (i < int'(lvl_use)) begin
				total_sum = total_sum + TOTAL_W'(occ_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= req_data.kind;
			prio_q <= req_data.element_priority;
			val_q  <= req_data.element_value;
		end
		if (cmd.exec) begin
			if (is_enq) begin
				if (!prio_ok) begin
					err_q <= ERR_PRIO;
				end else if (!enq_ok) begin
					err_q <= ERR_FULL;
				end else begin
					err_q <= ERR_OK;
				end
			end else if (is_deq) begin
				err_q <= top_found ? ERR_OK : ERR_EMPTY;
			end else begin
				err_q <= prio_ok ? ERR_OK : ERR_PRIO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else if (cmd.exec) begin
			if (enq_ok) begin
				tail_q[req_lvl] <= ptr_next(tail_q[req_lvl]);
				occ_q[req_lvl]  <= occ_q[req_lvl] + 1'b1;
			end else if (is_deq && top_found) begin
				head_q[top_idx] <= ptr_next(head_q[top_idx]);
				occ_q[top_idx]  <= occ_q[top_idx] - 1'b1;
			end
		end
	end

	// level store: write on enqueue, read the new head in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			mem[mem_addr(req_lvl, tail_q[req_lvl])] <= val_q;
		end
		if (cmd.find_top) begin
			rdata_q <= mem[mem_addr(top_idx, head_q[top_idx])];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find_top) begin
			top_valid_q <= top_found;
			top_lvl_q   <= top_idx;
			total_q     <= total_sum;
			lvl_cnt_q   <= prio_ok ? occ_q[req_lvl] : '0;
		end
	end

	assign stat.out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.head_value    <= top_valid_q ? rdata_q : '0;
			out_q.head_priority <= top_valid_q ? PRIO_W'(top_lvl_q) + 1'b1 : '0;
			out_q.queue_empty   <= !top_valid_q;
			out_q.total_count   <= total_q;
			out_q.level_count   <= LCOUNT_W'(lvl_cnt_q);
			out_q.error_code    <= err_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_deq && !top_found) |=> (err_q == ERR_EMPTY))
		else $error("removal from empty queue not flagged");
	a_top_vs_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find_top |=> (top_valid_q == (total_q != '0)))
		else $error("head presence disagrees with occupancy");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (out_valid_q && (out_q.queue_empty == (out_q.head_priority == '0))))
		else $error("result register inconsistent after load");

endmodule
`default_nettype wire

// ===== src/multilevel_priority_fifo_unit.sv =====
// channel | dir | handshake     | payload
// cfg     | in  | valid / ready | data: num_levels (4 bits)
// req     | in  | valid / ready | kind, element_priority, element_value
// rsp     | out | valid / ready | head_value, head_priority, queue_empty,
//         |     |               | total_count, level_count, error_code
//
// After acceptance a transaction runs through execute, head lookup through
// the registered level-store read, and the load into the result register.
// The next request is taken in the cycle after the result load, so requests
// do not overlap: a new one is accepted only once the last has been loaded.
// Reset clears pointers and occupancy at once; no clearing pass is needed.
// A stalled result holds in the output register while the next request is
// taken; a second result waits in the controller until the register frees.
`default_nettype none
module multilevel_priority_fifo_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mlpq_cfg_if.sink   cfg,
	mlpq_req_if.sink   req,
	mlpq_rsp_if.source rsp
);
	import mlpq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlpq_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.cfg      (cfg),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire
